/* sv/fosf_pkg.sv */
// Shared types and constants of the first-order shelving filter.
// Used by the interfaces, the controller, the datapath and the top level.
package fosf_pkg;

  localparam int unsigned CoefW     = 32;
  localparam int unsigned SampleIoW = 32;
  localparam int unsigned CfgAddrW  = 3;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] RegA0  = 3'd0;
  localparam logic [CfgAddrW-1:0] RegA1  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegB1  = 3'd2;
  localparam logic [CfgAddrW-1:0] RegWet = 3'd3;
  localparam logic [CfgAddrW-1:0] RegDry = 3'd4;

  localparam logic [CoefW-1:0] DryGainReset = 32'h0001_0000;

  // Input word modes.
  localparam logic ModeFilter = 1'b0;
  localparam logic ModeFlush  = 1'b1;

  typedef enum logic [2:0] {
    MUL_A0_X,
    MUL_A1_XP,
    MUL_B1_VP,
    MUL_DRY_X,
    MUL_WET_V
  } mul_src_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef struct packed {
    mul_src_e mul_sel;
    acc_op_e  acc_op;
    logic     load_x;
    logic     flush;
    logic     latch_v;
    logic     commit;
  } fosf_cmd_t;

  typedef struct packed {
    logic out_free;
  } fosf_sts_t;

endpackage

/* sv/fosf_if.sv */
// Valid/ready channel interfaces for input words and result words.
// Depends on fosf_pkg for the field widths.
interface fosf_in_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [fosf_pkg::SampleIoW-1:0]     sample_in;

  modport source (output valid, output mode, output sample_in, input ready);
  modport sink (input valid, input mode, input sample_in, output ready);
endinterface

interface fosf_out_if;
  logic                               valid;
  logic                               ready;
  logic [fosf_pkg::SampleIoW-1:0]     sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

/* sv/fosf_ctrl.sv */
// Sequencer of the shelving filter: steps one shared multiplier through
// five products per word. Depends on fosf_pkg for command and status types.
module fosf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_mode_i,
  output logic                in_ready_o,
  input  fosf_pkg::fosf_sts_t sts_i,
  output fosf_pkg::fosf_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_P0   = 3'd1;
  localparam logic [2:0] ST_P1   = 3'd2;
  localparam logic [2:0] ST_P2   = 3'd3;
  localparam logic [2:0] ST_P3   = 3'd4;
  localparam logic [2:0] ST_P4   = 3'd5;
  localparam logic [2:0] ST_ACC  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = fosf_pkg::MUL_A0_X;
    cmd_o.acc_op  = fosf_pkg::ACC_HOLD;
    in_ready_o    = 1'b0;
    state_d       = state_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_P0: begin
        cmd_o.mul_sel = fosf_pkg::MUL_A0_X;
        state_d       = ST_P1;
      end
      ST_P1: begin
        cmd_o.mul_sel = fosf_pkg::MUL_A1_XP;
        cmd_o.acc_op  = fosf_pkg::ACC_LOAD;
        state_d       = ST_P2;
      end
      ST_P2: begin
        cmd_o.mul_sel = fosf_pkg::MUL_B1_VP;
        cmd_o.acc_op  = fosf_pkg::ACC_ADD;
        state_d       = ST_P3;
      end
      ST_P3: begin
        cmd_o.mul_sel = fosf_pkg::MUL_DRY_X;
        cmd_o.acc_op  = fosf_pkg::ACC_SUB;
        state_d       = ST_P4;
      end
      ST_P4: begin
        // The accumulator holds the inner value here; it feeds the wet product.
        cmd_o.mul_sel = fosf_pkg::MUL_WET_V;
        cmd_o.acc_op  = fosf_pkg::ACC_LOAD;
        cmd_o.latch_v = 1'b1;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_op = fosf_pkg::ACC_ADD;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        in_ready_o = sts_i.out_free;
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
    endcase

    accept = in_valid_i && in_ready_o;
    if (accept) begin
      if (in_mode_i == fosf_pkg::ModeFlush) begin
        cmd_o.flush = 1'b1;
      end else begin
        cmd_o.load_x = 1'b1;
        state_d      = ST_P0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("result committed while the output register is occupied");

  a_filter_starts_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_mode_i == fosf_pkg::ModeFilter) |=> state_q == ST_P0)
    else $error("accepted filter word did not start the product chain");

  a_no_accept_midway: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_OUT) |-> !in_ready_o)
    else $error("input ready while a word is in progress");

  a_flush_load_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.flush && cmd_o.load_x))
    else $error("flush and sample load in the same cycle");

endmodule

/* sv/fosf_dp.sv */
// Datapath of the shelving filter: coefficient registers, filter state,
// one shared multiplier with an accumulator, and the output register.
// Depends on fosf_pkg; driven by fosf_ctrl commands.
module fosf_dp #(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fosf_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [fosf_pkg::CoefW-1:0]        cfg_wdata_i,
  input  logic [fosf_pkg::SampleIoW-1:0]    sample_in_i,
  input  fosf_pkg::fosf_cmd_t               cmd_i,
  output fosf_pkg::fosf_sts_t               sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fosf_pkg::SampleIoW-1:0]    sample_out_o
);

  localparam int unsigned CW   = fosf_pkg::CoefW;
  localparam int unsigned IoW  = fosf_pkg::SampleIoW;
  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned ProdW = CW + SW;

  logic signed [CW-1:0] a0_q, a1_q, b1_q, wet_q, dry_q;
  logic        [SW-1:0] x_q, px_q, pv_q, v_q;
  logic        [SW-1:0] p_q, p_d;
  logic        [SW-1:0] acc_q, acc_d;
  logic       [IoW-1:0] out_q;
  logic                 out_valid_q;

  logic signed [CW-1:0]    mul_a;
  logic signed [SW-1:0]    mul_b;
  logic signed [ProdW-1:0] prod;

  // Coefficient registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a0_q  <= '0;
      a1_q  <= '0;
      b1_q  <= '0;
      wet_q <= '0;
      dry_q <= fosf_pkg::DryGainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        fosf_pkg::RegA0:  a0_q  <= cfg_wdata_i;
        fosf_pkg::RegA1:  a1_q  <= cfg_wdata_i;
        fosf_pkg::RegB1:  b1_q  <= cfg_wdata_i;
        fosf_pkg::RegWet: wet_q <= cfg_wdata_i;
        fosf_pkg::RegDry: dry_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (cmd_i.mul_sel)
      fosf_pkg::MUL_A0_X:  begin mul_a = a0_q;  mul_b = x_q;   end
      fosf_pkg::MUL_A1_XP: begin mul_a = a1_q;  mul_b = px_q;  end
      fosf_pkg::MUL_B1_VP: begin mul_a = b1_q;  mul_b = pv_q;  end
      fosf_pkg::MUL_DRY_X: begin mul_a = dry_q; mul_b = x_q;   end
      fosf_pkg::MUL_WET_V: begin mul_a = wet_q; mul_b = acc_q; end
      default:             begin mul_a = a0_q;  mul_b = x_q;   end
    endcase
  end

  // Only the bits that survive the arithmetic shift and the wrap are kept.
  assign prod = mul_a * mul_b;
  assign p_d  = prod[FRAC_BITS+SW-1:FRAC_BITS];

  always_comb begin
    unique case (cmd_i.acc_op)
      fosf_pkg::ACC_HOLD: acc_d = acc_q;
      fosf_pkg::ACC_LOAD: acc_d = p_q;
      fosf_pkg::ACC_ADD:  acc_d = acc_q + p_q;
      fosf_pkg::ACC_SUB:  acc_d = acc_q - p_q;
      default:            acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    acc_q <= acc_d;
    if (cmd_i.load_x) begin
      x_q <= sample_in_i[SW-1:0];
    end
    if (cmd_i.latch_v) begin
      v_q <= acc_q;
    end
    if (cmd_i.commit) begin
      out_q <= IoW'($signed(acc_q));
    end
  end

  // Filter state; a flush in the same cycle as a commit wins.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      pv_q <= '0;
    end else if (cmd_i.flush) begin
      px_q <= '0;
      pv_q <= '0;
    end else if (cmd_i.commit) begin
      px_q <= x_q;
      pv_q <= v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = out_q;

endmodule

/* sv/first_order_shelving_filter.sv */
// First-order shelving filter: one shared multiplier, five products per word.
// A filter word passes the states P0 to P4, ACC and OUT; its result is registered when
// OUT finds the output register free. The next filter word is taken in IDLE, or in OUT
// as the result is committed; a flush word clears the filter state and gives no result.
// Reset clears filter state and all coefficients but dry, unity at FRAC_BITS 16.
module first_order_shelving_filter #(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fosf_in_if.sink                       in_i,
  fosf_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [fosf_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [fosf_pkg::CoefW-1:0]    cfg_wdata_i
);

  fosf_pkg::fosf_cmd_t cmd;
  fosf_pkg::fosf_sts_t sts;
  logic                in_ready;
  logic                out_valid;
  logic [fosf_pkg::SampleIoW-1:0] sample_out;

  fosf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fosf_dp #(
    .FRAC_BITS    (FRAC_BITS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_in_i  (in_i.sample_in),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_o.ready),
    .sample_out_o (sample_out)
  );

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid;
  assign out_o.sample_out = sample_out;

endmodule
